[hdl/mctd_pkg.sv]
// Shared types, character codes and the Morse code table for the text decoder.
`timescale 1ns / 1ps
`default_nettype none
package mctd_pkg;

   localparam int MORSE_MAX_SYMBOLS = 5;
   localparam int MORSE_CODES       = 36;
   localparam int LETTERS           = 26;

   localparam logic [2:0] MODE_NONE   = 3'd0;
   localparam logic [2:0] MODE_MORSE  = 3'd1;
   localparam logic [2:0] MODE_BINARY = 3'd2;
   localparam logic [2:0] MODE_HEX    = 3'd3;
   localparam logic [2:0] MODE_CAESAR = 3'd4;
   localparam logic [2:0] MODE_ATBASH = 3'd5;

   localparam logic ITEM_CHAR  = 1'b0;
   localparam logic ITEM_FLUSH = 1'b1;

   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_DASH  = 8'h2D;
   localparam logic [7:0] CHR_DOT   = 8'h2E;
   localparam logic [7:0] CHR_SLASH = 8'h2F;
   localparam logic [7:0] CHR_0     = 8'h30;
   localparam logic [7:0] CHR_1     = 8'h31;
   localparam logic [7:0] CHR_9     = 8'h39;
   localparam logic [7:0] CHR_QMARK = 8'h3F;
   localparam logic [7:0] CHR_A     = 8'h41;
   localparam logic [7:0] CHR_D     = 8'h44;
   localparam logic [7:0] CHR_F     = 8'h46;
   localparam logic [7:0] CHR_Z     = 8'h5A;

   // Symbol count and pattern (dash = 1, last symbol in bit 0) per code.
   localparam logic [2:0] MORSE_LEN [MORSE_CODES] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2,
      3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3,
      3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
      3'd5, 3'd5
   };
   localparam logic [4:0] MORSE_PAT [MORSE_CODES] = '{
      5'd1,  5'd8,  5'd10, 5'd4,  5'd0,  5'd2,  5'd6,  5'd0,  5'd0,
      5'd7,  5'd5,  5'd4,  5'd3,  5'd2,  5'd7,  5'd6,  5'd13, 5'd2,
      5'd0,  5'd1,  5'd1,  5'd1,  5'd3,  5'd9,  5'd11, 5'd12,
      5'd31, 5'd15, 5'd7,  5'd3,  5'd1,  5'd0,  5'd16, 5'd24,
      5'd28, 5'd30
   };

   typedef struct packed {
      logic [1:0] count;
      logic [7:0] ch0;
      logic [7:0] ch1;
   } mctd_res_type;

   function automatic logic [7:0] morse_lookup(input logic [7:0] value,
                                               input logic [2:0] length);
      logic [7:0] mask;
      logic [7:0] sym;
      logic       found;
      mask  = 8'((9'd1 << length) - 9'd1);
      sym   = CHR_QMARK;
      found = 1'b0;
      if (length <= 3'(MORSE_MAX_SYMBOLS) && length <= 3'd5) begin
         for (int i = 0; i < MORSE_CODES; i++) begin
            if (!found && MORSE_LEN[i] == length &&
                (value & mask) == {3'd0, MORSE_PAT[i]}) begin
               found = 1'b1;
               sym   = (i < LETTERS) ? 8'(int'(CHR_A) + i)
                                     : 8'(int'(CHR_0) + i - LETTERS);
            end
         end
      end
      return sym;
   endfunction

endpackage
`default_nettype wire

[hdl/mctd_decode.sv]
// Per-character decode and the open-word state.
`timescale 1ns / 1ps
`default_nettype none
module mctd_decode
   import mctd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire logic [2:0]   cipher_mode,
   input  wire logic         item_mode,
   input  wire logic [7:0]   char_code,
   output mctd_res_type      res
);

   logic [7:0] word_value_ff, word_value_in;
   logic [2:0] word_length_ff, word_length_in;

   logic       word_mode;
   logic       got;
   logic [7:0] close_ch;
   logic       sym_ok;
   logic       narrow;
   logic [3:0] digit;
   logic [7:0] c;

   assign c         = char_code;
   assign word_mode = (cipher_mode == MODE_MORSE) || (cipher_mode == MODE_BINARY) ||
                      (cipher_mode == MODE_HEX);
   assign got       = (word_length_ff != 3'd0) && word_mode;
   assign close_ch  = (cipher_mode == MODE_MORSE) ?
                      morse_lookup(word_value_ff, word_length_ff) : word_value_ff;

   // symbol classification for the word modes
   always_comb begin
      sym_ok = 1'b0;
      narrow = 1'b1;
      digit  = 4'd0;
      unique case (cipher_mode)
         MODE_MORSE: begin
            sym_ok = (c == CHR_DOT) || (c == CHR_DASH);
            digit  = {3'd0, c == CHR_DASH};
         end
         MODE_BINARY: begin
            sym_ok = (c == CHR_0) || (c == CHR_1);
            digit  = {3'd0, c == CHR_1};
         end
         MODE_HEX: begin
            narrow = 1'b0;
            if (c >= CHR_0 && c <= CHR_9) begin
               sym_ok = 1'b1;
               digit  = 4'(c - CHR_0);
            end else if (c >= CHR_A && c <= CHR_F) begin
               sym_ok = 1'b1;
               digit  = 4'(c - CHR_A + 8'd10);
            end
         end
         default: begin
            sym_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      res            = '0;
      res.ch0        = CHR_SPACE;
      res.ch1        = CHR_SPACE;
      word_value_in  = word_value_ff;
      word_length_in = word_length_ff;
      if (item_mode == ITEM_FLUSH) begin
         word_value_in  = 8'd0;
         word_length_in = 3'd0;
         if (got) begin
            res.count = 2'd1;
            res.ch0   = close_ch;
         end else if (cipher_mode == MODE_CAESAR || cipher_mode == MODE_ATBASH) begin
            res.count = 2'd1;
         end
      end else if (word_mode) begin
         if (c == CHR_SPACE || c == CHR_SLASH) begin
            word_value_in  = 8'd0;
            word_length_in = 3'd0;
            // a closed word goes first, the slash's space after it
            if (got) begin
               res.ch0 = close_ch;
            end
            res.count = {1'b0, got} + {1'b0, c == CHR_SLASH};
         end else if (sym_ok) begin
            word_value_in  = narrow ? {word_value_ff[6:0], digit[0]}
                                    : {word_value_ff[3:0], digit};
            word_length_in = (word_length_ff == 3'd7) ? 3'd7 : word_length_ff + 3'd1;
         end
      end else if (cipher_mode == MODE_CAESAR || cipher_mode == MODE_ATBASH) begin
         if (c == CHR_SPACE) begin
            res.count = 2'd1;
         end else if (c >= CHR_A && c <= CHR_Z) begin
            res.count = 2'd1;
            if (cipher_mode == MODE_CAESAR) begin
               res.ch0 = (c < CHR_D) ? c + 8'd23 : c - 8'd3;
            end else begin
               res.ch0 = CHR_Z - (c - CHR_A);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_value_ff  <= 8'd0;
         word_length_ff <= 3'd0;
      end else if (accept) begin
         word_value_ff  <= word_value_in;
         word_length_ff <= word_length_in;
      end
   end

endmodule
`default_nettype wire

[hdl/mctd_result_queue.sv]
// Pending-result register and output register; drains up to two characters per item.
`timescale 1ns / 1ps
`default_nettype none
module mctd_result_queue
   import mctd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load,
   input  wire mctd_res_type res,
   output logic              load_ok,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_run_last
);

   logic [1:0] pcnt_ff, pcnt_in;
   logic [7:0] pch0_ff, pch0_in;
   logic [7:0] pch1_ff, pch1_in;
   logic       ovalid_ff, ovalid_in;
   logic [7:0] ochar_ff, ochar_in;
   logic       olast_ff, olast_in;

   logic o_take;
   logic move;

   assign o_take  = !ovalid_ff || rsp_ready;
   assign move    = (pcnt_ff != 2'd0) && o_take;
   assign load_ok = (pcnt_ff == 2'd0) || (pcnt_ff == 2'd1 && move);

   always_comb begin
      pcnt_in   = pcnt_ff;
      pch0_in   = pch0_ff;
      pch1_in   = pch1_ff;
      ovalid_in = ovalid_ff;
      ochar_in  = ochar_ff;
      olast_in  = olast_ff;
      if (load) begin
         pcnt_in = res.count;
         pch0_in = res.ch0;
         pch1_in = res.ch1;
      end else if (move) begin
         pcnt_in = pcnt_ff - 2'd1;
         pch0_in = pch1_ff;
      end
      if (move) begin
         ovalid_in = 1'b1;
         ochar_in  = pch0_ff;
         olast_in  = (pcnt_ff == 2'd1);
      end else if (rsp_ready) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff   <= 2'd0;
         ovalid_ff <= 1'b0;
      end else begin
         pcnt_ff   <= pcnt_in;
         ovalid_ff <= ovalid_in;
      end
      pch0_ff  <= pch0_in;
      pch1_ff  <= pch1_in;
      ochar_ff <= ochar_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid    = ovalid_ff;
   assign rsp_out_char = ochar_ff;
   assign rsp_run_last = olast_ff;

endmodule
`default_nettype wire

[hdl/multi_cipher_text_decoder_unit.sv]
// Top level of the multi-cipher text decoder: register port, decode and result queue.
//
// Usage:
//  - req channel: one beat per character (req_mode = 0) or end-of-message flush
//    (req_mode = 1). req_char_code is ignored on flush beats.
//  - rsp channel: 0, 1 or 2 beats per request; rsp_run_last marks the last beat
//    of a request. Requests that produce nothing emit no beat.
//  - csr port: register 0 (byte addresses 0 to 3) is cipher_mode, 3 bits. Write it only
//    while no request is in flight. Addresses 4 to 7 read as zero.
//  - Path: an accepted request's beats pass through the pending register, then the output register.
//  - Throughput: one request per cycle while rsp_ready is high and each gives at most
//    one beat; a request with two beats holds req_ready low until its first beat has
//    moved on, since the single output register moves at most one character per cycle.
//  - The word state is updated at accept time, so decode of one request depends
//    only on requests accepted earlier.
//  - Stall: when rsp_ready is low the output beat holds, the pending register
//    fills, and req_ready drops once it cannot take another request.
//  - Reset: synchronous; clears cipher_mode, the open word and all pending beats.
`timescale 1ns / 1ps
`default_nettype none
module multi_cipher_text_decoder_unit
   import mctd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic [7:0]  req_char_code,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_run_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [2:0]   cipher_mode_ff, cipher_mode_in;
   logic         csr_write;
   logic         accept;
   mctd_res_type res;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign accept     = req_valid && req_ready;

   assign cipher_mode_in = (csr_write && csr_paddr[2] == 1'b0) ? csr_pwdata[2:0]
                                                               : cipher_mode_ff;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {29'd0, cipher_mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cipher_mode_ff <= MODE_NONE;
      end else begin
         cipher_mode_ff <= cipher_mode_in;
      end
   end

   mctd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cipher_mode (cipher_mode_ff),
      .item_mode   (req_mode),
      .char_code   (req_char_code),
      .res         (res)
   );

   mctd_result_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .load         (accept),
      .res          (res),
      .load_ok      (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_run_last (rsp_run_last)
   );

endmodule
`default_nettype wire

[hdl/mctd_checker.sv]
// Port-level checks for the text decoder and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mctd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_char,
   input wire logic       rsp_run_last,
   input wire logic       csr_pready
);

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) &&
                                  $stable(rsp_run_last))
      else $error("rsp beat changed while stalled");

   // reset drops pending beats and reopens the request side
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state not cleared by reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr_pready low");

endmodule

bind multi_cipher_text_decoder_unit mctd_checker u_mctd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_char (rsp_out_char),
   .rsp_run_last (rsp_run_last),
   .csr_pready   (csr_pready)
);
`default_nettype wire
